@@ hdl/egcd_pkg.sv @@
// ----------------------------------------------------------------------------
// egcd_pkg
// shared types and constants for the extended gcd core: payload structs,
// controller states and the command / status bundles between the two halves
// ----------------------------------------------------------------------------
package egcd_pkg;

	localparam int unsigned OPER_W  = 63;
	localparam int unsigned COEF_W  = 64;
	localparam int unsigned SHIFT_W = $clog2(OPER_W);

	typedef struct packed {
		logic [OPER_W-1:0] first_operand;
		logic [OPER_W-1:0] second_operand;
	} egcd_in_t;

	typedef struct packed {
		logic        [OPER_W-1:0] gcd_value;
		logic signed [COEF_W-1:0] coef_a;
		logic signed [COEF_W-1:0] coef_b;
	} egcd_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ALIGN,
		ST_DIVIDE,
		ST_UPDATE,
		ST_FINISH
	} egcd_state_t;

	typedef struct packed {
		logic load;
		logic start_div;
		logic align;
		logic div_step;
		logic update;
		logic capture;
	} egcd_cmd_t;

	typedef struct packed {
		logic r1_zero;
		logic can_align;
		logic shift_zero;
	} egcd_status_t;

endpackage

@@ hdl/egcd_ctrl.sv @@
// ----------------------------------------------------------------------------
// egcd_ctrl
// sequencer for the euclid loop: per step a divisor alignment pass, then one
// quotient bit per cycle, then the remainder / coefficient rotation
// ----------------------------------------------------------------------------
module egcd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  egcd_pkg::egcd_status_t status,
	output egcd_pkg::egcd_cmd_t   cmd
);
	import egcd_pkg::*;

	egcd_state_t state_q;
	egcd_state_t state_next;
	logic        out_valid_q;
	logic        out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.capture) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_CHECK;
			end
			ST_CHECK: begin
				state_next = status.r1_zero ? ST_FINISH : ST_ALIGN;
			end
			ST_ALIGN: begin
				if (!status.can_align) state_next = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (status.shift_zero) state_next = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_next = ST_CHECK;
			end
			ST_FINISH: begin
				if (out_free) state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// datapath commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:   cmd.load      = in_valid;
			ST_CHECK:  cmd.start_div = !status.r1_zero;
			ST_ALIGN:  cmd.align     = status.can_align;
			ST_DIVIDE: cmd.div_step  = 1'b1;
			ST_UPDATE: cmd.update    = 1'b1;
			ST_FINISH: cmd.capture   = out_free;
			default:   cmd           = '0;
		endcase
	end

endmodule

@@ hdl/egcd_datapath.sv @@
// ----------------------------------------------------------------------------
// egcd_datapath
// remainder pair, bezout coefficient pairs, shift-subtract divider with
// horner accumulation of q*s1 and q*t1, and the result register
// ----------------------------------------------------------------------------
module egcd_datapath (
	input  logic                   clk,
	input  egcd_pkg::egcd_in_t     in_data,
	input  egcd_pkg::egcd_cmd_t    cmd,
	output egcd_pkg::egcd_status_t status,
	output egcd_pkg::egcd_out_t    out_data
);
	import egcd_pkg::*;

	logic [OPER_W-1:0]  r0_q, r1_q, d_q;
	logic [SHIFT_W-1:0] k_q;
	logic [COEF_W-1:0]  s0_q, s1_q, t0_q, t1_q, ps_q, pt_q;
	egcd_out_t          out_q;

	logic               q_bit;
	logic [COEF_W-1:0]  ps_add, pt_add;

	// quotient bit at the current shift
	assign q_bit  = (d_q <= r0_q);
	assign ps_add = q_bit ? s1_q : '0;
	assign pt_add = q_bit ? t1_q : '0;

	assign status.r1_zero    = (r1_q == '0);
	assign status.can_align  = !d_q[OPER_W-1] && ({d_q, 1'b0} <= {1'b0, r0_q});
	assign status.shift_zero = (k_q == '0);

	assign out_data = out_q;

	always_ff @(posedge clk) begin
		priority if (cmd.load) begin
			r0_q <= in_data.first_operand;
			r1_q <= in_data.second_operand;
			s0_q <= COEF_W'(1);
			s1_q <= '0;
			t0_q <= '0;
			t1_q <= COEF_W'(1);
		end else if (cmd.start_div) begin
			d_q  <= r1_q;
			k_q  <= '0;
			ps_q <= '0;
			pt_q <= '0;
		end else if (cmd.align) begin
			d_q <= {d_q[OPER_W-2:0], 1'b0};
			k_q <= k_q + SHIFT_W'(1);
		end else if (cmd.div_step) begin
			if (q_bit) r0_q <= r0_q - d_q;
			ps_q <= {ps_q[COEF_W-2:0], 1'b0} + ps_add;
			pt_q <= {pt_q[COEF_W-2:0], 1'b0} + pt_add;
			if (k_q != '0) begin
				d_q <= {1'b0, d_q[OPER_W-1:1]};
				k_q <= k_q - SHIFT_W'(1);
			end
		end else if (cmd.update) begin
			// r0 holds the remainder here
			r0_q <= r1_q;
			r1_q <= r0_q;
			s0_q <= s1_q;
			s1_q <= s0_q - ps_q;
			t0_q <= t1_q;
			t1_q <= t0_q - pt_q;
		end else if (cmd.capture) begin
			out_q.gcd_value <= r0_q;
			out_q.coef_a    <= s0_q;
			out_q.coef_b    <= t0_q;
		end
	end

endmodule

@@ hdl/extended_gcd_mod_inverse_core.sv @@
// ----------------------------------------------------------------------------
// extended_gcd_mod_inverse_core
// extended euclidean algorithm: gcd and bezout coefficients of two 63-bit
// operands, coef_a doubling as the unreduced modular inverse of a mod b
// ----------------------------------------------------------------------------
// operation: each euclid step runs an alignment pass and then a shift-subtract
//   pass of the divider; a zero second operand goes straight to the result
// throughput: one item at a time; the next item is taken once the last step
//   is done, while the previous result may still sit in the output register
// reset: arst_n clears the controller and the output valid; data regs hold
// ----------------------------------------------------------------------------
module extended_gcd_mod_inverse_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  egcd_pkg::egcd_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output egcd_pkg::egcd_out_t out_data
);
	import egcd_pkg::*;

	// command and status bundles between sequencer and datapath
	egcd_cmd_t    cmd;
	egcd_status_t status;

	// controller: idle, per-step check / align / divide / update, finish
	egcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath: remainders, coefficients, divider and the result register
	egcd_datapath u_datapath (
		.clk      (clk),
		.in_data  (in_data),
		.cmd      (cmd),
		.status   (status),
		.out_data (out_data)
	);

endmodule

@@ tb/egcd_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// egcd_checker
// watches both channels of the extended gcd core, works out the gcd and
// bezout pair for every accepted operand pair and compares each result with
// the oldest one still owed
// ----------------------------------------------------------------------------
module egcd_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  egcd_pkg::egcd_in_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  egcd_pkg::egcd_out_t out_data,
	output int                  fail_count,
	output int                  pending_count,
	output int                  checked_count,
	output int                  zero_b_count,
	output int                  common_factor_count
);

	import egcd_pkg::*;

	typedef struct {
		egcd_in_t  operands;
		egcd_out_t result;
	} bezout_entry_t;

	bezout_entry_t owed_results[$];
	bezout_entry_t head_entry;
	bezout_entry_t new_entry;

	initial begin
		fail_count          = 0;
		pending_count       = 0;
		checked_count       = 0;
		zero_b_count        = 0;
		common_factor_count = 0;
	end

	// remainder sequence with truncated quotients, coefficients wrap at 64 bits
	function automatic egcd_out_t bezout_of(egcd_in_t item);
		logic [63:0] r0, r1, s0, s1, t0, t1;
		logic [63:0] quot, nr, ns, nt;
		int          step;
		egcd_out_t   res;
		r0   = {1'b0, item.first_operand};
		r1   = {1'b0, item.second_operand};
		s0   = 64'd1;
		s1   = 64'd0;
		t0   = 64'd0;
		t1   = 64'd1;
		step = 0;
		while (r1 != 64'd0 && step < 128) begin
			quot = r0 / r1;
			nr   = r0 - quot * r1;
			ns   = s0 - quot * s1;
			nt   = t0 - quot * t1;
			r0   = r1;
			r1   = nr;
			s0   = s1;
			s1   = ns;
			t0   = t1;
			t1   = nt;
			step++;
		end
		res.gcd_value = r0[OPER_W-1:0];
		res.coef_a    = s0;
		res.coef_b    = t0;
		return res;
	endfunction

	task automatic compare_field(input string field, input egcd_in_t ops,
			input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			fail_count++;
			$error("%s: expected %h, actual %h (a=%h b=%h)", field, want, got,
				ops.first_operand, ops.second_operand);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_results.delete();
			pending_count = 0;
		end else begin
			if (in_valid && in_ready) begin
				new_entry.operands = in_data;
				new_entry.result   = bezout_of(in_data);
				owed_results.push_back(new_entry);
				if (in_data.second_operand == '0)
					zero_b_count++;
				if (new_entry.result.gcd_value > 1)
					common_factor_count++;
			end
			if (out_valid && out_ready) begin
				if (owed_results.size() == 0) begin
					fail_count++;
					$error("gcd_value: expected nothing, actual %h (unexpected item)",
						out_data.gcd_value);
				end else begin
					head_entry = owed_results.pop_front();
					compare_field("gcd_value", head_entry.operands,
						{1'b0, head_entry.result.gcd_value}, {1'b0, out_data.gcd_value});
					compare_field("coef_a", head_entry.operands,
						head_entry.result.coef_a, out_data.coef_a);
					compare_field("coef_b", head_entry.operands,
						head_entry.result.coef_b, out_data.coef_b);
					checked_count++;
				end
			end
			pending_count = owed_results.size();
		end
	end

endmodule

@@ tb/extended_gcd_mod_inverse_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// extended_gcd_mod_inverse_core_tb
// drives operand pairs into the extended gcd core and lets egcd_checker
// compare every gcd / bezout result; directed corner pairs come first, then
// a random mix of full-width, short, common-factor and fibonacci operands,
// with bursty input traffic and a receiver that stalls in several patterns
// ----------------------------------------------------------------------------
module extended_gcd_mod_inverse_core_tb;

	import egcd_pkg::*;

	localparam int RANDOM_ITEMS = 1330;
	// drain time after the store empties; plenty to catch strays
	localparam int DRAIN_CYCLES = 600;
	localparam logic [62:0] OPER_MAX = {63{1'b1}};

	typedef enum int {
		RX_STEADY,
		RX_CHOPPY,
		RX_LONG_STALL
	} rx_mode_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	egcd_in_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	egcd_out_t out_data;

	int fail_count;
	int pending_count;
	int checked_count;
	int zero_b_count;
	int common_factor_count;

	int          directed_count = 0;
	int          burst_left     = 0;
	int          gap_len        = 0;
	logic [62:0] fib_seq [0:92];

	// receiver pattern state
	rx_mode_t rx_mode    = RX_STEADY;
	int       mode_left  = 0;
	int       stall_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	extended_gcd_mod_inverse_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	egcd_checker u_checker (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.in_data             (in_data),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.out_data            (out_data),
		.fail_count          (fail_count),
		.pending_count       (pending_count),
		.checked_count       (checked_count),
		.zero_b_count        (zero_b_count),
		.common_factor_count (common_factor_count)
	);

	// hard stop in case the core hangs; far above the slowest legal run
	initial begin
		#(64'd250_000_000);
		$display("TB_ERROR");
		$finish;
	end

	// receiver: switches between always ready, short random stalls and rare
	// long stalls, picking a new mode at random when the current one runs out
	always @(negedge clk) begin
		if (mode_left == 0) begin
			rx_mode   = rx_mode_t'($urandom_range(0, 2));
			mode_left = $urandom_range(100, 400);
		end else begin
			mode_left--;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_STEADY: begin
					out_ready <= 1'b1;
				end
				RX_CHOPPY: begin
					if ($urandom_range(0, 2) == 0)
						stall_left = $urandom_range(0, 2);
					out_ready <= ($urandom_range(0, 2) != 0);
				end
				default: begin
					if ($urandom_range(0, 15) == 0) begin
						stall_left = $urandom_range(5, 40);
						out_ready <= 1'b0;
					end else begin
						out_ready <= 1'b1;
					end
				end
			endcase
		end
	end

	// one item on the input channel, then either stay in the burst or open
	// a gap; valid stays high straight into the next item inside a burst
	task automatic drive_item(input logic [62:0] a, input logic [62:0] b);
		@(negedge clk);
		in_valid               <= 1'b1;
		in_data.first_operand  <= a;
		in_data.second_operand <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 12);
			gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap_len > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap_len - 1)
					@(negedge clk);
			end
		end
	endtask

	task automatic drive_directed(input logic [62:0] a, input logic [62:0] b);
		directed_count++;
		drive_item(a, b);
	endtask

	// random value of the given bit length (63 = full width)
	function automatic logic [62:0] rand_bits(input int unsigned width);
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		if (width >= 63)
			return raw[62:0];
		return raw[62:0] & ((63'd1 << width) - 63'd1);
	endfunction

	task automatic drive_random_item();
		int          kind;
		int          fw;
		int          k;
		logic [62:0] a, b, factor;
		kind = $urandom_range(0, 99);
		if (kind < 35) begin
			// full width, mostly coprime or with a tiny gcd
			a = rand_bits(63);
			b = rand_bits(63);
		end else if (kind < 60) begin
			// independent lengths so both a < b and a >> b show up
			a = rand_bits($urandom_range(1, 63));
			b = rand_bits($urandom_range(1, 63));
		end else if (kind < 75) begin
			// no inverse: both share a factor, product kept inside 63 bits
			fw     = $urandom_range(1, 24);
			factor = rand_bits(fw);
			if (factor == '0)
				factor = 63'd2;
			a = factor * rand_bits($urandom_range(0, 63 - fw));
			b = factor * rand_bits($urandom_range(0, 63 - fw));
		end else if (kind < 83) begin
			// neighboring fibonacci numbers give the longest remainder chains
			k = $urandom_range(2, 92);
			if ($urandom_range(0, 1) == 0) begin
				a = fib_seq[k];
				b = fib_seq[k-1];
			end else begin
				a = fib_seq[k-1];
				b = fib_seq[k];
			end
		end else if (kind < 90) begin
			a = rand_bits(5);
			b = rand_bits(5);
		end else if (kind < 95) begin
			// one operand zero
			a = rand_bits($urandom_range(1, 63));
			b = '0;
			if ($urandom_range(0, 1) == 0) begin
				b = a;
				a = '0;
			end
		end else begin
			// equal operands, or b dividing a exactly
			b = rand_bits($urandom_range(1, 40));
			a = b * rand_bits($urandom_range(0, 22));
			if ($urandom_range(0, 1) == 0)
				a = b;
		end
		drive_item(a, b);
	endtask

	initial begin
		fib_seq[0] = 63'd0;
		fib_seq[1] = 63'd1;
		for (int i = 2; i <= 92; i++)
			fib_seq[i] = fib_seq[i-1] + fib_seq[i-2];

		// single reset at the start of the run
		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed corners
		drive_directed(63'd0, 63'd0);                   // both zero
		drive_directed(OPER_MAX, 63'd0);                // zero modulus
		drive_directed(63'd1, 63'd0);
		drive_directed(63'd0, OPER_MAX);                // first operand zero
		drive_directed(63'd0, 63'd1);
		drive_directed(OPER_MAX, OPER_MAX);             // equal, all ones
		drive_directed(63'd1, OPER_MAX);
		drive_directed(OPER_MAX, 63'd1);
		drive_directed(OPER_MAX, OPER_MAX - 63'd1);
		drive_directed(fib_seq[92], fib_seq[91]);       // longest chain
		drive_directed(fib_seq[91], fib_seq[92]);
		drive_directed(63'd3, 63'd7);                   // plain inverse
		drive_directed(63'd7, 63'd3);
		drive_directed(63'd12, 63'd18);                 // no inverse
		drive_directed(63'd6, 63'd9);
		drive_directed(63'd10, 63'd10);
		drive_directed(63'd1 << 62, 63'd1 << 61);       // powers of two
		drive_directed(63'd1 << 62, 63'd3);
		drive_directed(OPER_MAX, 63'd1 << 62);
		drive_directed({1'b1, {31{2'b01}}}, {1'b0, {31{2'b10}}}); // alternating bits
		drive_directed(63'd1_000_000_006, 63'd1_000_000_007);
		drive_directed(OPER_MAX - 63'd24, 63'd1_000_000_007);

		for (int n = 0; n < RANDOM_ITEMS; n++)
			drive_random_item();

		@(negedge clk);
		in_valid <= 1'b0;

		// every item gives one result, so an empty store means the core is idle;
		// the extra cycles catch any stray output
		wait (pending_count == 0);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("covered %0d operand pairs (%0d directed, %0d random), %0d results compared",
			directed_count + RANDOM_ITEMS, directed_count, RANDOM_ITEMS, checked_count);
		$display("%0d pairs with a zero modulus, %0d with a common factor, %0d field mismatches",
			zero_b_count, common_factor_count, fail_count);
		if (fail_count == 0 && pending_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ files.f @@
hdl/egcd_pkg.sv
hdl/egcd_ctrl.sv
hdl/egcd_datapath.sv
hdl/extended_gcd_mod_inverse_core.sv
tb/egcd_checker.sv
tb/extended_gcd_mod_inverse_core_tb.sv
